// ===== sv/assert_macros.svh =====
// ============================================================================
// assert_macros.svh
// Shared concurrent assertion macros for the ray/triangle test block
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must never be true at a clock edge outside reset
`define RTI_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("rti assertion failed");

// consequent must hold in the cycle after the antecedent
`define RTI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rti assertion failed");

`endif

// ===== sv/rti_pkg.sv =====
// ============================================================================
// rti_pkg
// Widths, register codes and shared types of the ray/triangle test block
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package rti_pkg;

    // coordinate format
    localparam int CW  = 32;
    localparam int FB  = 16;

    // derived widths of the exact intermediate values
    localparam int EW  = CW + 1;          // edges and s vector
    localparam int SW  = CW + 1;
    localparam int PW  = 2 * CW + 2;      // p = dir x e1
    localparam int QW  = 2 * CW + 3;      // q = s x e0
    localparam int DW  = 3 * CW + 6;      // dot products, det, numerator

    // shared multiplier operand widths
    localparam int MB  = CW + 2;
    localparam int MA  = 2 * MB;
    localparam int MP  = MA + MB;
    localparam int NMUL = 24;

    // distance and divider widths
    localparam int QTW = 32;
    localparam int NW  = DW + QTW + 2;

    // pipeline depths
    localparam int NFS = 14;
    localparam int QD  = 4;
    localparam int QAW = 2;

    // configuration port
    localparam int APB_AW = 6;
    localparam int APB_DW = 64;
    localparam int DMW    = 63;

    localparam logic [2:0] REG_ORIGIN_X = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [2:0] REG_DIR_X    = 3'd3;
    localparam logic [2:0] REG_DIR_Y    = 3'd4;
    localparam logic [2:0] REG_DIR_Z    = 3'd5;
    localparam logic [2:0] REG_DET_MIN  = 3'd6;

    localparam logic [DMW-1:0] DET_MIN_RESET = 63'd28147497671;
    localparam logic [CW-1:0]  ONE_Q = {{(CW-FB-1){1'b0}}, 1'b1, {FB{1'b0}}};

    localparam logic [QTW-1:0] DIST_MAX = {1'b0, {(QTW-1){1'b1}}};
    localparam logic [QTW-1:0] DIST_MIN = {1'b1, {(QTW-1){1'b0}}};

    // ray held in configuration
    typedef struct packed {
        logic [2:0][CW-1:0] org;
        logic [2:0][CW-1:0] dir;
        logic [DMW-1:0]     det_min;
    } ray_cfg_t;

    localparam ray_cfg_t CFG_RESET = '{
        org:     '0,
        dir:     {ONE_Q, {CW{1'b0}}, {CW{1'b0}}},
        det_min: DET_MIN_RESET
    };

    // classified item handed from front to back
    typedef struct packed {
        logic              hit;
        logic signed [DW-1:0] num;
        logic signed [DW-1:0] det;
    } q_item_t;

endpackage

`default_nettype wire

// ===== sv/rti_mul.sv =====
// ============================================================================
// rti_mul
// Two-stage signed multiplier built from two narrow partial products
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module rti_mul (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [rti_pkg::MA-1:0] a,
    input  logic signed [rti_pkg::MB-1:0] b,
    output logic signed [rti_pkg::MP-1:0] prod
);
    import rti_pkg::*;

    logic signed [2*MB:0]   pl_next;
    logic signed [2*MB-1:0] ph_next;
    logic signed [2*MB:0]   pl_reg;
    logic signed [2*MB-1:0] ph_reg;
    logic signed [MP-1:0]   prod_next;
    logic signed [MP-1:0]   prod_reg;

    // low half unsigned, high half signed
    assign pl_next = $signed({1'b0, a[MB-1:0]}) * b;
    assign ph_next = $signed(a[MA-1:MB]) * b;

    // recombine the partial products
    assign prod_next = (MP'(ph_reg) <<< MB) + MP'(pl_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pl_reg   <= pl_next;
            ph_reg   <= ph_next;
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ===== sv/rti_front.sv =====
// ============================================================================
// rti_front
// Front pipeline: edges, determinant, barycentric tests and t numerator
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module rti_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rti_pkg::ray_cfg_t             cfg,
    input  logic                          tri_valid,
    output logic                          tri_stall,
    input  logic signed [rti_pkg::CW-1:0] vert_a_x,
    input  logic signed [rti_pkg::CW-1:0] vert_a_y,
    input  logic signed [rti_pkg::CW-1:0] vert_a_z,
    input  logic signed [rti_pkg::CW-1:0] vert_b_x,
    input  logic signed [rti_pkg::CW-1:0] vert_b_y,
    input  logic signed [rti_pkg::CW-1:0] vert_b_z,
    input  logic signed [rti_pkg::CW-1:0] vert_c_x,
    input  logic signed [rti_pkg::CW-1:0] vert_c_y,
    input  logic signed [rti_pkg::CW-1:0] vert_c_z,
    input  logic                          q_full,
    output logic                          q_push,
    output rti_pkg::q_item_t              q_data
);
    import rti_pkg::*;

    typedef struct {
        logic                 valid;
        logic signed [EW-1:0] e0 [3];
        logic signed [EW-1:0] e1 [3];
        logic signed [CW-1:0] va [3];
        logic signed [PW-1:0] p  [3];
        logic signed [SW-1:0] s  [3];
        logic signed [QW-1:0] q  [3];
        logic signed [DW-1:0] det;
        logic                 det_ok;
        logic signed [DW-1:0] us;
        logic signed [DW-1:0] vs;
        logic signed [DW-1:0] num;
        logic                 hit;
    } fe_t;

    fe_t stg_reg  [NFS];
    fe_t stg_next [NFS];

    logic                 adv;
    logic                 acc;
    logic signed [CW-1:0] va  [3];
    logic signed [CW-1:0] vb  [3];
    logic signed [CW-1:0] vc  [3];
    logic signed [CW-1:0] org [3];
    logic signed [CW-1:0] dir [3];
    logic signed [MA-1:0] mul_a [NMUL];
    logic signed [MB-1:0] mul_b [NMUL];
    logic signed [MP-1:0] mul_p [NMUL];
    logic signed [DW-1:0] thr;
    logic signed [DW-1:0] det_raw;
    logic                 det_pos;

    assign va[0] = vert_a_x;
    assign va[1] = vert_a_y;
    assign va[2] = vert_a_z;
    assign vb[0] = vert_b_x;
    assign vb[1] = vert_b_y;
    assign vb[2] = vert_b_z;
    assign vc[0] = vert_c_x;
    assign vc[1] = vert_c_y;
    assign vc[2] = vert_c_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            org[i] = $signed(cfg.org[i]);
            dir[i] = $signed(cfg.dir[i]);
        end
    end

    assign thr = $signed(DW'(cfg.det_min));

    // whole pipeline holds only when the last stage cannot drain
    assign adv       = !(stg_reg[NFS-1].valid && q_full);
    assign tri_stall = !adv;
    assign acc       = tri_valid && adv;
    assign q_push    = stg_reg[NFS-1].valid && !q_full;

    assign q_data.hit = stg_reg[NFS-1].hit;
    assign q_data.num = stg_reg[NFS-1].num;
    assign q_data.det = stg_reg[NFS-1].det;

    // multiplier operands per stage
    always_comb
    begin
        // p = dir x e1
        mul_a[0] = MA'(dir[1]); mul_b[0] = MB'(stg_reg[0].e1[2]);
        mul_a[1] = MA'(dir[2]); mul_b[1] = MB'(stg_reg[0].e1[1]);
        mul_a[2] = MA'(dir[2]); mul_b[2] = MB'(stg_reg[0].e1[0]);
        mul_a[3] = MA'(dir[0]); mul_b[3] = MB'(stg_reg[0].e1[2]);
        mul_a[4] = MA'(dir[0]); mul_b[4] = MB'(stg_reg[0].e1[1]);
        mul_a[5] = MA'(dir[1]); mul_b[5] = MB'(stg_reg[0].e1[0]);
        for (int i = 0; i < 3; i++)
        begin
            // det = p . e0
            mul_a[6+i]  = MA'(stg_reg[3].p[i]);
            mul_b[6+i]  = MB'(stg_reg[3].e0[i]);
            // u numerator = p . s
            mul_a[9+i]  = MA'(stg_reg[6].p[i]);
            mul_b[9+i]  = MB'(stg_reg[6].s[i]);
            // v numerator = q . dir
            mul_a[18+i] = MA'(stg_reg[9].q[i]);
            mul_b[18+i] = MB'(dir[i]);
            // t numerator = q . e1
            mul_a[21+i] = MA'(stg_reg[9].q[i]);
            mul_b[21+i] = MB'(stg_reg[9].e1[i]);
        end
        // q = s x e0
        mul_a[12] = MA'(stg_reg[6].s[1]); mul_b[12] = MB'(stg_reg[6].e0[2]);
        mul_a[13] = MA'(stg_reg[6].s[2]); mul_b[13] = MB'(stg_reg[6].e0[1]);
        mul_a[14] = MA'(stg_reg[6].s[2]); mul_b[14] = MB'(stg_reg[6].e0[0]);
        mul_a[15] = MA'(stg_reg[6].s[0]); mul_b[15] = MB'(stg_reg[6].e0[2]);
        mul_a[16] = MA'(stg_reg[6].s[0]); mul_b[16] = MB'(stg_reg[6].e0[1]);
        mul_a[17] = MA'(stg_reg[6].s[1]); mul_b[17] = MB'(stg_reg[6].e0[0]);
    end

    genvar gm;
    generate
        for (gm = 0; gm < NMUL; gm++)
        begin : g_mul
            rti_mul u_mul (
                .clk  (clk),
                .en   (adv),
                .a    (mul_a[gm]),
                .b    (mul_b[gm]),
                .prod (mul_p[gm])
            );
        end
    endgenerate

    // determinant sign fold
    assign det_raw = mul_p[6] + mul_p[7] + mul_p[8];
    assign det_pos = !det_raw[DW-1] && (det_raw != '0);

    // stage next values
    always_comb
    begin
        stg_next[0] = stg_reg[0];
        for (int k = 1; k < NFS; k++)
            stg_next[k] = stg_reg[k-1];

        // edges
        stg_next[0].valid = acc;
        for (int i = 0; i < 3; i++)
        begin
            stg_next[0].e0[i] = EW'(vb[i]) - EW'(va[i]);
            stg_next[0].e1[i] = EW'(vc[i]) - EW'(va[i]);
            stg_next[0].va[i] = va[i];
        end

        // p vector
        stg_next[3].p[0] = PW'(mul_p[0] - mul_p[1]);
        stg_next[3].p[1] = PW'(mul_p[2] - mul_p[3]);
        stg_next[3].p[2] = PW'(mul_p[4] - mul_p[5]);

        // positive determinant and s vector
        stg_next[6].det = det_pos ? det_raw : -det_raw;
        for (int i = 0; i < 3; i++)
        begin
            stg_next[6].s[i] = det_pos ? SW'(org[i]) - SW'(stg_reg[5].va[i])
                                       : SW'(stg_reg[5].va[i]) - SW'(org[i]);
        end

        // u numerator, q vector, parallel test
        stg_next[9].us     = mul_p[9] + mul_p[10] + mul_p[11];
        stg_next[9].q[0]   = QW'(mul_p[12] - mul_p[13]);
        stg_next[9].q[1]   = QW'(mul_p[14] - mul_p[15]);
        stg_next[9].q[2]   = QW'(mul_p[16] - mul_p[17]);
        stg_next[9].det_ok = stg_reg[8].det >= thr;

        // v and t numerators
        stg_next[12].vs  = mul_p[18] + mul_p[19] + mul_p[20];
        stg_next[12].num = mul_p[21] + mul_p[22] + mul_p[23];

        // hit classification
        stg_next[13].hit = stg_reg[12].det_ok
                           && !stg_reg[12].us[DW-1]
                           && (stg_reg[12].us <= stg_reg[12].det)
                           && !stg_reg[12].vs[DW-1]
                           && ((stg_reg[12].us + stg_reg[12].vs) <= stg_reg[12].det);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NFS; k++)
                stg_reg[k].valid <= 1'b0;
        end
        else if (adv)
        begin
            for (int k = 0; k < NFS; k++)
                stg_reg[k] <= stg_next[k];
        end
    end

endmodule

`default_nettype wire

// ===== sv/rti_queue.sv =====
// ============================================================================
// rti_queue
// Short item queue between the front and back pipelines
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rti_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  rti_pkg::q_item_t push_data,
    output logic             full,
    input  logic             pop,
    output rti_pkg::q_item_t pop_data,
    output logic             empty
);
    import rti_pkg::*;

    q_item_t        fifo_mem [QD];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW-1:0] rd_ptr_next;
    logic [QAW:0]   count_reg;
    logic [QAW:0]   count_next;

    assign full     = count_reg == (QAW+1)'(QD);
    assign empty    = count_reg == '0;
    assign pop_data = fifo_mem[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            fifo_mem[wr_ptr_reg] <= push_data;
    end

    `RTI_ASSERT_NEVER(a_no_push_full, push && full)
    `RTI_ASSERT_NEVER(a_no_pop_empty, pop && empty)
    `RTI_ASSERT_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

`default_nettype wire

// ===== sv/rti_back.sv =====
// ============================================================================
// rti_back
// Back pipeline: one quotient bit per stage for t, saturation, result register
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module rti_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_empty,
    input  rti_pkg::q_item_t               q_data,
    output logic                           q_pop,
    output logic                           res_valid,
    input  logic                           res_stall,
    output logic                           hit,
    output logic signed [rti_pkg::QTW-1:0] distance
);
    import rti_pkg::*;

    typedef struct {
        logic           valid;
        logic           hit;
        logic           neg;
        logic           ovf;
        logic [NW-1:0]  rem;
        logic [DW-1:0]  den;
        logic [QTW-1:0] quo;
    } bk_t;

    bk_t bstg_reg  [QTW+1];
    bk_t bstg_next [QTW+1];

    logic           adv;
    logic           num_neg;
    logic [DW-1:0]  num_mag;
    logic [NW-1:0]  rem_init;
    logic           ovld_reg;
    logic           ovld_next;
    logic           hit_reg;
    logic           hit_next;
    logic [QTW-1:0] dist_reg;
    logic [QTW-1:0] dist_next;

    assign adv   = !ovld_reg || !res_stall;
    assign q_pop = adv && !q_empty;

    // magnitude of the scaled numerator
    assign num_neg  = q_data.num[DW-1];
    assign num_mag  = num_neg ? -q_data.num : q_data.num;
    assign rem_init = NW'(num_mag) << FB;

    // load and restoring division steps
    always_comb
    begin
        logic [NW-1:0] sh;
        bstg_next[0].valid = !q_empty;
        bstg_next[0].hit   = q_data.hit;
        bstg_next[0].neg   = num_neg;
        bstg_next[0].rem   = rem_init;
        bstg_next[0].den   = $unsigned(q_data.det);
        bstg_next[0].ovf   = rem_init >= (NW'($unsigned(q_data.det)) << QTW);
        bstg_next[0].quo   = '0;
        for (int k = 1; k <= QTW; k++)
        begin
            bstg_next[k] = bstg_reg[k-1];
            sh = NW'(bstg_reg[k-1].den) << (QTW - k);
            if (bstg_reg[k-1].rem >= sh)
            begin
                bstg_next[k].rem         = bstg_reg[k-1].rem - sh;
                bstg_next[k].quo[QTW-k]  = 1'b1;
            end
        end
    end

    // saturate into the signed distance
    always_comb
    begin
        ovld_next = bstg_reg[QTW].valid;
        hit_next  = bstg_reg[QTW].hit;
        if (!bstg_reg[QTW].hit)
            dist_next = DIST_MAX;
        else if (bstg_reg[QTW].ovf)
            dist_next = bstg_reg[QTW].neg ? DIST_MIN : DIST_MAX;
        else if (!bstg_reg[QTW].neg)
            dist_next = bstg_reg[QTW].quo[QTW-1] ? DIST_MAX : bstg_reg[QTW].quo;
        else
            dist_next = bstg_reg[QTW].quo[QTW-1] ? DIST_MIN : -bstg_reg[QTW].quo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QTW; k++)
                bstg_reg[k].valid <= 1'b0;
            ovld_reg <= 1'b0;
        end
        else if (adv)
        begin
            for (int k = 0; k <= QTW; k++)
                bstg_reg[k] <= bstg_next[k];
            ovld_reg <= ovld_next;
            hit_reg  <= hit_next;
            dist_reg <= dist_next;
        end
    end

    assign res_valid = ovld_reg;
    assign hit       = hit_reg;
    assign distance  = $signed(dist_reg);

endmodule

`default_nettype wire

// ===== sv/ray_triangle_intersection.sv =====
// ============================================================================
// ray_triangle_intersection
// Moller-Trumbore ray/triangle test against a ray held in registers
// ============================================================================
// Usage:
//   Program the ray (origin, direction, signed Q16.16) and the determinant
//   threshold through the APB port at byte addresses 8*i, only while idle.
//   Triangles enter on tri_valid/tri_stall with the nine vertex coordinates;
//   an item is taken at an edge where tri_valid is high and tri_stall low.
//   Each triangle yields one result on res_valid/res_stall: hit and the
//   saturated Q16.16 distance t (0x7FFFFFFF on a miss).
//   Throughput is one triangle per cycle while tri_stall and res_stall stay
//   low. From acceptance to res_valid an item passes 14 front stages
//   (with registered multipliers), the queue, 33 divider stages (a load
//   stage, then one per quotient bit) and the result register.
//   When res_stall is held the back pipeline freezes; the 4-entry queue
//   keeps the front running until it fills, then tri_stall rises.
//   Reset clears all valid state and loads origin 0, direction (0,0,1.0)
//   and the default threshold.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ray_triangle_intersection (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rti_pkg::APB_AW-1:0]        paddr,
    input  logic [rti_pkg::APB_DW-1:0]        pwdata,
    output logic [rti_pkg::APB_DW-1:0]        prdata,
    output logic                              pready,
    input  logic                              tri_valid,
    output logic                              tri_stall,
    input  logic signed [rti_pkg::CW-1:0]     vert_a_x,
    input  logic signed [rti_pkg::CW-1:0]     vert_a_y,
    input  logic signed [rti_pkg::CW-1:0]     vert_a_z,
    input  logic signed [rti_pkg::CW-1:0]     vert_b_x,
    input  logic signed [rti_pkg::CW-1:0]     vert_b_y,
    input  logic signed [rti_pkg::CW-1:0]     vert_b_z,
    input  logic signed [rti_pkg::CW-1:0]     vert_c_x,
    input  logic signed [rti_pkg::CW-1:0]     vert_c_y,
    input  logic signed [rti_pkg::CW-1:0]     vert_c_z,
    output logic                              res_valid,
    input  logic                              res_stall,
    output logic                              hit,
    output logic signed [rti_pkg::QTW-1:0]    distance
);
    import rti_pkg::*;

    ray_cfg_t   cfg_reg;
    ray_cfg_t   cfg_next;
    logic       wr_en;
    logic [2:0] reg_idx;
    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;
    q_item_t    q_in;
    q_item_t    q_out;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[APB_AW-1:3];

    // register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_ORIGIN_X: cfg_next.org[0]  = pwdata[CW-1:0];
                REG_ORIGIN_Y: cfg_next.org[1]  = pwdata[CW-1:0];
                REG_ORIGIN_Z: cfg_next.org[2]  = pwdata[CW-1:0];
                REG_DIR_X:    cfg_next.dir[0]  = pwdata[CW-1:0];
                REG_DIR_Y:    cfg_next.dir[1]  = pwdata[CW-1:0];
                REG_DIR_Z:    cfg_next.dir[2]  = pwdata[CW-1:0];
                REG_DET_MIN:  cfg_next.det_min = pwdata[DMW-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    // register reads
    always_comb
    begin
        case (reg_idx)
            REG_ORIGIN_X: prdata = APB_DW'(cfg_reg.org[0]);
            REG_ORIGIN_Y: prdata = APB_DW'(cfg_reg.org[1]);
            REG_ORIGIN_Z: prdata = APB_DW'(cfg_reg.org[2]);
            REG_DIR_X:    prdata = APB_DW'(cfg_reg.dir[0]);
            REG_DIR_Y:    prdata = APB_DW'(cfg_reg.dir[1]);
            REG_DIR_Z:    prdata = APB_DW'(cfg_reg.dir[2]);
            REG_DET_MIN:  prdata = APB_DW'(cfg_reg.det_min);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

    // front: geometry and classification
    rti_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .tri_valid (tri_valid),
        .tri_stall (tri_stall),
        .vert_a_x  (vert_a_x),
        .vert_a_y  (vert_a_y),
        .vert_a_z  (vert_a_z),
        .vert_b_x  (vert_b_x),
        .vert_b_y  (vert_b_y),
        .vert_b_z  (vert_b_z),
        .vert_c_x  (vert_c_x),
        .vert_c_y  (vert_c_y),
        .vert_c_z  (vert_c_z),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    // decoupling queue
    rti_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    // back: distance division and result
    rti_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_out),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .hit       (hit),
        .distance  (distance)
    );

endmodule

`default_nettype wire

// ===== dv/ray_triangle_intersection_test.sv =====
// ----------------------------------------------------------------------------
// ray_triangle_intersection_test
// Streams triangles through the intersection block against a series of rays
// and thresholds, predicts hit and distance with exact 128-bit arithmetic and
// checks every result in order, with random source gaps and sink stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ray_triangle_intersection_test;
    import rti_pkg::*;

    typedef logic signed [127:0] wide_t;
    typedef logic signed [CW-1:0] coord_t;

    typedef struct {
        coord_t a[3];
        coord_t b[3];
        coord_t c[3];
    } triangle_t;

    typedef struct {
        logic         hit;
        logic [31:0]  dist_q;
    } hit_result_t;

    localparam int  ONE = 65536;
    localparam int  CYCLE_LIMIT = 600000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [APB_AW-1:0]  paddr = '0;
    logic [APB_DW-1:0]  pwdata = '0;
    logic [APB_DW-1:0]  prdata;
    logic               pready;
    logic               tri_valid = 1'b0;
    logic               tri_stall;
    coord_t             vert_a_x = '0, vert_a_y = '0, vert_a_z = '0;
    coord_t             vert_b_x = '0, vert_b_y = '0, vert_b_z = '0;
    coord_t             vert_c_x = '0, vert_c_y = '0, vert_c_z = '0;
    logic               res_valid;
    logic               res_stall = 1'b0;
    logic               hit;
    logic signed [31:0] distance;

    // ray and threshold as the block should hold them
    coord_t             ray_org[3];
    coord_t             ray_dir[3];
    logic [DMW-1:0]     ray_det_min;

    hit_result_t        predicted_hits[$];
    int                 mismatches = 0;
    int                 cycles = 0;
    int                 stall_mode = 0;
    int                 stall_left = 0;
    int                 burst_left = 0;
    bit                 gaps_on = 1'b1;

    ray_triangle_intersection dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .tri_valid(tri_valid), .tri_stall(tri_stall),
        .vert_a_x(vert_a_x), .vert_a_y(vert_a_y), .vert_a_z(vert_a_z),
        .vert_b_x(vert_b_x), .vert_b_y(vert_b_y), .vert_b_z(vert_b_z),
        .vert_c_x(vert_c_x), .vert_c_y(vert_c_y), .vert_c_z(vert_c_z),
        .res_valid(res_valid), .res_stall(res_stall),
        .hit(hit), .distance(distance)
    );

    always #5 clk = ~clk;

    // vector helpers for the exact predictor
    function automatic void cross3(input wide_t x[3], input wide_t y[3],
                                   output wide_t r[3]);
        r[0] = x[1] * y[2] - x[2] * y[1];
        r[1] = x[2] * y[0] - x[0] * y[2];
        r[2] = x[0] * y[1] - x[1] * y[0];
    endfunction

    function automatic wide_t dot3(input wide_t x[3], input wide_t y[3]);
        return x[0] * y[0] + x[1] * y[1] + x[2] * y[2];
    endfunction

    // moller-trumbore with division-free rejects, t truncated and saturated
    function automatic hit_result_t intersect_triangle(input triangle_t tr);
        wide_t       va[3], org[3], dir[3], e0[3], e1[3], p[3], q[3], s[3];
        wide_t       det, thr, us, vs, num, mag, quo;
        bit          pos, neg;
        hit_result_t r;
        for (int i = 0; i < 3; i++)
        begin
            va[i]  = tr.a[i];
            e0[i]  = wide_t'(tr.b[i]) - va[i];
            e1[i]  = wide_t'(tr.c[i]) - va[i];
            org[i] = ray_org[i];
            dir[i] = ray_dir[i];
        end
        cross3(dir, e1, p);
        det = dot3(p, e0);
        pos = det > 0;
        for (int i = 0; i < 3; i++)
            s[i] = pos ? org[i] - va[i] : va[i] - org[i];
        if (!pos)
            det = -det;
        r.hit    = 1'b0;
        r.dist_q = DIST_MAX;
        thr = ray_det_min;
        if (det < thr)
            return r;
        us = dot3(p, s);
        if (us < 0 || us > det)
            return r;
        cross3(s, e0, q);
        vs = dot3(q, dir);
        if (vs < 0 || us + vs > det)
            return r;
        r.hit = 1'b1;
        num = dot3(q, e1);
        neg = num < 0;
        mag = (neg ? -num : num) <<< FB;
        if (det == 0)
            r.dist_q = neg ? DIST_MIN : DIST_MAX;
        else
        begin
            quo = mag / det;
            if (!neg)
                r.dist_q = (quo > 128'sh7FFFFFFF) ? DIST_MAX : quo[31:0];
            else
                r.dist_q = (quo >= 128'sh80000000) ? DIST_MIN : -quo[31:0];
        end
        return r;
    endfunction

    // sink stall patterns
    always @(posedge clk)
    begin
        case (stall_mode)
            0: res_stall <= 1'b0;
            1: res_stall <= ($urandom_range(0, 99) < 35);
            default:
            begin
                if (stall_left == 0)
                begin
                    stall_left = $urandom_range(1, 20);
                    res_stall <= ~res_stall;
                end
                else
                    stall_left = stall_left - 1;
            end
        endcase
    end

    // result checker
    always @(posedge clk)
    begin
        hit_result_t want;
        cycles <= cycles + 1;
        if (rst_n && res_valid && !res_stall)
        begin
            if (predicted_hits.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: hit=%0d distance=%h", hit, distance);
            end
            else
            begin
                want = predicted_hits.pop_front();
                if (hit !== want.hit || distance !== want.dist_q)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected hit=%0d distance=%h, got hit=%0d distance=%h",
                                 want.hit, want.dist_q, hit, distance);
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // one configuration register write, setup then access
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ORIGIN_X: ray_org[0] = value[31:0];
            REG_ORIGIN_Y: ray_org[1] = value[31:0];
            REG_ORIGIN_Z: ray_org[2] = value[31:0];
            REG_DIR_X:    ray_dir[0] = value[31:0];
            REG_DIR_Y:    ray_dir[1] = value[31:0];
            REG_DIR_Z:    ray_dir[2] = value[31:0];
            REG_DET_MIN:  ray_det_min = value[DMW-1:0];
            default: ;
        endcase
    endtask

    task automatic set_ray(input coord_t ox, input coord_t oy, input coord_t oz,
                           input coord_t dx, input coord_t dy, input coord_t dz,
                           input logic [63:0] dmin);
        write_reg(REG_ORIGIN_X, {{32{ox[31]}}, ox});
        write_reg(REG_ORIGIN_Y, {{32{oy[31]}}, oy});
        write_reg(REG_ORIGIN_Z, {{32{oz[31]}}, oz});
        write_reg(REG_DIR_X, {{32{dx[31]}}, dx});
        write_reg(REG_DIR_Y, {{32{dy[31]}}, dy});
        write_reg(REG_DIR_Z, {{32{dz[31]}}, dz});
        write_reg(REG_DET_MIN, dmin);
    endtask

    // send one triangle item, with bursts and gaps on the source side
    task automatic send_triangle(input triangle_t tr);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on && $urandom_range(0, 2) != 0)
            begin
                tri_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
        burst_left = burst_left - 1;
        tri_valid <= 1'b1;
        vert_a_x <= tr.a[0]; vert_a_y <= tr.a[1]; vert_a_z <= tr.a[2];
        vert_b_x <= tr.b[0]; vert_b_y <= tr.b[1]; vert_b_z <= tr.b[2];
        vert_c_x <= tr.c[0]; vert_c_y <= tr.c[1]; vert_c_z <= tr.c[2];
        do
            @(posedge clk);
        while (tri_stall);
        predicted_hits.push_back(intersect_triangle(tr));
    endtask

    task automatic send_coords(input int ax, input int ay, input int az,
                               input int bx, input int by, input int bz,
                               input int cx, input int cy, input int cz);
        triangle_t tr;
        tr.a = '{ax, ay, az};
        tr.b = '{bx, by, bz};
        tr.c = '{cx, cy, cz};
        send_triangle(tr);
    endtask

    // idle the source and let every expected item come back
    task automatic drain;
        tri_valid <= 1'b0;
        burst_left = 0;
        while (predicted_hits.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // triangle whose centroid sits at ray parameter t, optionally pushed aside
    task automatic send_around_ray(input int t, input int shift, input int spread);
        triangle_t tr;
        longint    pt[3];
        int        u, w;
        for (int i = 0; i < 3; i++)
        begin
            pt[i] = longint'(ray_org[i]) + ((longint'(ray_dir[i]) * t) >>> FB) + shift;
            u = $urandom_range(0, 2 * spread) - spread;
            w = $urandom_range(0, 2 * spread) - spread;
            tr.a[i] = coord_t'(pt[i] + u);
            tr.b[i] = coord_t'(pt[i] + w);
            tr.c[i] = coord_t'(pt[i] - u - w);
        end
        send_triangle(tr);
    endtask

    task automatic send_noise;
        triangle_t tr;
        for (int i = 0; i < 3; i++)
        begin
            tr.a[i] = $urandom;
            tr.b[i] = $urandom;
            tr.c[i] = $urandom;
        end
        send_triangle(tr);
    endtask

    // default ray along +z: hits, misses on each barycentric bound, extremes
    task automatic test_reset_ray;
        stall_mode = 0;
        gaps_on = 1'b0;
        send_coords(-ONE, -ONE, 5*ONE, 2*ONE, -ONE, 5*ONE, -ONE, 2*ONE, 5*ONE);
        send_coords(-ONE, -ONE, -3*ONE, 2*ONE, -ONE, -3*ONE, -ONE, 2*ONE, -3*ONE);
        send_coords(ONE, -ONE, 5*ONE, 4*ONE, -ONE, 5*ONE, ONE, 2*ONE, 5*ONE);
        send_coords(-ONE, ONE, 5*ONE, 2*ONE, ONE, 5*ONE, -ONE, 4*ONE, 5*ONE);
        send_coords(ONE, ONE, 5*ONE, 3*ONE, ONE, 5*ONE, ONE, 3*ONE, 5*ONE);
        send_coords(-ONE, 0, 0, ONE, 0, 5*ONE, 0, 0, 9*ONE);
        send_coords(-ONE, -ONE, 5*ONE, 2*ONE, -ONE, 5*ONE + 1, -ONE, -ONE + 1, 5*ONE);
        send_coords(-ONE, -ONE, 7*ONE, 2*ONE, -ONE, 2*ONE, -ONE, 2*ONE, 9*ONE);
        send_coords(0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_coords(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                    32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        send_coords(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                    32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
        send_coords(32'h80000000, 32'h80000000, 5*ONE, 32'h7FFFFFFF, 32'h80000000, 5*ONE,
                    32'h80000000, 32'h7FFFFFFF, 5*ONE);
        drain();
    endtask

    // tiny direction and zero threshold: saturated t and zero determinant
    task automatic test_saturation;
        set_ray(0, 0, 0, 0, 0, 1, 64'd0);
        send_coords(-ONE, -ONE, 20000*ONE, 2*ONE, -ONE, 20000*ONE, -ONE, 2*ONE, 20000*ONE);
        send_coords(-ONE, -ONE, -20000*ONE, 2*ONE, -ONE, -20000*ONE, -ONE, 2*ONE,
                    -20000*ONE);
        send_coords(0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_coords(ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE);
        send_coords(-ONE, 0, 0, ONE, 0, 5*ONE, 0, 0, 9*ONE);
        drain();
        set_ray(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                32'h80000000, 64'd0);
        send_coords(0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_coords(32'h7FFFFFFF, 0, 0, 0, 32'h80000000, 0, 0, 0, 32'h7FFFFFFF);
        drain();
    endtask

    // threshold at its top: triangles around the ray are rejected as parallel, then noise
    task automatic test_threshold_max;
        stall_mode = 1;
        gaps_on = 1'b1;
        set_ray(0, 0, 0, 0, 0, ONE, 64'h7FFFFFFFFFFFFFFF);
        repeat (40) send_around_ray($urandom_range(0, 10*ONE), 0, 1 << 18);
        repeat (20) send_noise();
        drain();
    endtask

    // random rays with mostly well-formed triangles around them
    task automatic test_random_rays;
        int kind;
        for (int phase = 0; phase < 12; phase++)
        begin
            stall_mode = phase % 3;
            gaps_on = (phase % 4) != 3;
            if (phase == 11)
                set_ray($urandom, $urandom, $urandom, $urandom, $urandom,
                        -int'($urandom_range(0, 32'h7FFFFFFF)) - 1,
                        {$urandom, $urandom});
            else
                set_ray($urandom_range(0, 1 << 21) - (1 << 20),
                        $urandom_range(0, 1 << 21) - (1 << 20),
                        $urandom_range(0, 1 << 21) - (1 << 20),
                        $urandom_range(0, 1 << 18) - (1 << 17),
                        $urandom_range(0, 1 << 18) - (1 << 17),
                        $urandom_range(0, (1 << 17) + ONE) - (1 << 17),
                        (phase % 5 == 0) ? 64'd0 : 64'($urandom_range(0, 1 << 30)));
            for (int n = 0; n < 100; n++)
            begin
                kind = $urandom_range(0, 99);
                if (kind < 70)
                    send_around_ray($urandom_range(0, 20*ONE) - 2*ONE, 0,
                                    1 << $urandom_range(8, 19));
                else if (kind < 85)
                    send_around_ray($urandom_range(0, 20*ONE),
                                    $urandom_range(0, 1 << 20) - (1 << 19), 1 << 16);
                else
                    send_noise();
            end
            drain();
        end
    endtask

    initial
    begin
        ray_org = '{0, 0, 0};
        ray_dir = '{0, 0, ONE};
        ray_det_min = DET_MIN_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_ray();
        test_saturation();
        test_threshold_max();
        test_random_rays();
        if (mismatches == 0 && predicted_hits.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
